### design/cisd_pkg.sv
// Types and constants shared by the CBOR item stream decoder.
package cisd_pkg;

  typedef enum logic [2:0] {
    EV_ABSORB  = 3'd0,
    EV_HEAD    = 3'd1,
    EV_PAYLOAD = 3'd2,
    EV_VALUE   = 3'd3,
    EV_ERROR   = 3'd4
  } event_e;

  typedef enum logic [2:0] {
    ERR_NONE       = 3'd0,
    ERR_NESTED_TAG = 3'd1,
    ERR_RESERVED   = 3'd2,
    ERR_SIMPLE     = 3'd3,
    ERR_BIGINT_LEN = 3'd4
  } err_e;

  typedef enum logic [4:0] {
    PH_IDLE    = 5'b00001,
    PH_ARG     = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_FIXED   = 5'b01000,
    PH_HALT    = 5'b10000
  } phase_e;

  localparam logic [3:0] KindPos    = 4'd0;
  localparam logic [3:0] KindBin    = 4'd2;
  localparam logic [3:0] KindStr    = 4'd3;
  localparam logic [3:0] KindFalse  = 4'd6;
  localparam logic [3:0] KindBreak  = 4'd10;
  localparam logic [3:0] KindF16    = 4'd11;
  localparam logic [3:0] KindBigint = 4'd14;

  localparam logic [2:0] MajorTag       = 3'b110;
  localparam logic [4:0] LastDirectInfo = 5'd23;
  localparam logic [4:0] LastArgInfo    = 5'd27;
  localparam logic [4:0] BigintTagNum   = 5'h02;  // low bits of tag byte 0xC2
  localparam logic [3:0] BigintBytes    = 4'd8;

  typedef struct packed {
    event_e      event_res;
    logic [3:0]  kind;
    logic [63:0] value;
    logic [7:0]  payload_byte;
    logic        last;
    logic        tagged_res;
    logic [4:0]  tag_number;
    err_e        error_code;
  } res_t;

endpackage

### design/cbor_item_stream_decoder.sv
// CBOR item stream decoder: head, payload and fixed-width value decoding.
//
// Usage:
//   Input channel: one CBOR byte per request on data_byte_i, qualified by
//   in_valid_i and held off by in_stall_o. Output channel: one result per
//   input byte (event, kind, value, payload byte, last mark, tag fields,
//   error code), qualified by out_valid_o and held off by out_stall_i.
//   Output: a byte's result is registered and appears in the cycle after
//   the byte is accepted. Throughput: one byte per cycle while the output
//   is not stalled; all decoding happens in the single logic stage between
//   the decoder state and the output register, which sets the rate.
//   Stall: while the output register holds a result that is stalled, the
//   input is stalled too; the result and the decoder state are held.
//   Reset: clears the output valid, returns the decoder to waiting for a
//   head byte with no tag held and no error latched.
//   Errors: after an error every further byte answers with an error event
//   carrying the latched code, until reset.
module cbor_item_stream_decoder (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [2:0]            event_res_o,
  output logic [3:0]            kind_o,
  output logic [63:0]           value_o,
  output logic [7:0]            payload_byte_o,
  output logic                  last_o,
  output logic                  tagged_res_o,
  output logic [4:0]            tag_number_o,
  output logic [2:0]            error_code_o
);
  import cisd_pkg::*;

  phase_e      phase_q, phase_d;
  logic [3:0]  left_q, left_d;
  logic [63:0] acc_q, acc_d;
  logic [63:0] remain_q, remain_d;
  logic [3:0]  cur_kind_q, cur_kind_d;
  logic [4:0]  held_tag_q, held_tag_d;
  logic        tag_held_q, tag_held_d;
  err_e        err_q, err_d;
  logic        out_valid_q, out_valid_d;
  res_t        res_q, res_d;
  logic        accept;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign accept     = in_valid_i & ~in_stall_o;

  always_comb begin
    logic [2:0]  major;
    logic [4:0]  info;
    logic [63:0] acc_n;
    logic [3:0]  left_n;
    logic [63:0] remain_n;
    logic        do_head;
    logic [3:0]  head_kind;
    logic [63:0] head_arg;
    logic        take;
    logic        drop;
    logic        fail;
    err_e        fail_code;

    major     = data_byte_i[7:5];
    info      = data_byte_i[4:0];
    acc_n     = {acc_q[55:0], data_byte_i};
    left_n    = left_q - 4'd1;
    remain_n  = remain_q - 64'd1;
    do_head   = 1'b0;
    head_kind = KindPos;
    head_arg  = '0;
    take      = 1'b0;
    drop      = 1'b0;
    fail      = 1'b0;
    fail_code = ERR_NONE;

    phase_d    = phase_q;
    left_d     = left_q;
    acc_d      = acc_q;
    remain_d   = remain_q;
    cur_kind_d = cur_kind_q;
    err_d      = err_q;
    res_d      = '0;
    res_d.event_res  = EV_ABSORB;
    res_d.error_code = ERR_NONE;

    case (phase_q)
      PH_HALT: begin
        fail      = 1'b1;
        fail_code = err_q;
      end
      PH_ARG: begin
        acc_d  = acc_n;
        left_d = left_n;
        if (left_n == 4'd0) begin
          do_head   = 1'b1;
          head_kind = cur_kind_q;
          head_arg  = acc_n;
        end
      end
      PH_PAYLOAD: begin
        remain_d           = remain_n;
        res_d.event_res    = EV_PAYLOAD;
        res_d.kind         = cur_kind_q;
        res_d.payload_byte = data_byte_i;
        res_d.last         = (remain_n == 64'd0);
        if (remain_n == 64'd0) begin
          phase_d = PH_IDLE;
          drop    = 1'b1;
        end
      end
      PH_FIXED: begin
        acc_d  = acc_n;
        left_d = left_n;
        if (left_n == 4'd0) begin
          res_d.event_res = EV_VALUE;
          res_d.kind      = cur_kind_q;
          res_d.value     = acc_n;
          phase_d         = PH_IDLE;
          drop            = 1'b1;
        end
      end
      default: begin
        phase_d = PH_IDLE;
        if (major == MajorTag) begin
          if (tag_held_q) begin
            fail      = 1'b1;
            fail_code = ERR_NESTED_TAG;
          end else begin
            take = 1'b1;
          end
        end else if (major < MajorTag) begin
          if (info > LastArgInfo) begin
            fail      = 1'b1;
            fail_code = ERR_RESERVED;
          end else if (info <= LastDirectInfo) begin
            do_head   = 1'b1;
            head_kind = {1'b0, major};
            head_arg  = {59'd0, info};
          end else begin
            // argument of 1, 2, 4 or 8 bytes follows
            phase_d    = PH_ARG;
            cur_kind_d = {1'b0, major};
            left_d     = 4'd1 << info[1:0];
            acc_d      = '0;
          end
        end else if (data_byte_i inside {[8'hF4:8'hF7]}) begin
          res_d.event_res = EV_HEAD;
          res_d.kind      = KindFalse + {2'b00, data_byte_i[1:0]};
          drop            = 1'b1;
        end else if (data_byte_i == 8'hFF) begin
          res_d.event_res = EV_HEAD;
          res_d.kind      = KindBreak;
          drop            = 1'b1;
        end else if (data_byte_i inside {[8'hF9:8'hFB]}) begin
          // float16/32/64 collect 2, 4 or 8 raw bytes
          phase_d    = PH_FIXED;
          cur_kind_d = KindF16 - 4'd1 + {2'b00, data_byte_i[1:0]};
          left_d     = 4'd1 << data_byte_i[1:0];
          acc_d      = '0;
        end else begin
          fail      = 1'b1;
          fail_code = ERR_SIMPLE;
        end
      end
    endcase

    if (do_head) begin
      if (head_kind == KindBin && tag_held_q && held_tag_q == BigintTagNum) begin
        if (head_arg != {60'd0, BigintBytes}) begin
          fail      = 1'b1;
          fail_code = ERR_BIGINT_LEN;
        end else begin
          phase_d    = PH_FIXED;
          cur_kind_d = KindBigint;
          left_d     = BigintBytes;
          acc_d      = '0;
        end
      end else begin
        res_d.event_res = EV_HEAD;
        res_d.kind      = head_kind;
        res_d.value     = head_arg;
        if ((head_kind == KindBin || head_kind == KindStr) && head_arg != 64'd0) begin
          phase_d    = PH_PAYLOAD;
          cur_kind_d = head_kind;
          remain_d   = head_arg;
        end else begin
          phase_d = PH_IDLE;
          drop    = 1'b1;
        end
      end
    end

    // tag fields show the tag of this byte's item, before any drop
    if (fail) begin
      phase_d          = PH_HALT;
      err_d            = fail_code;
      res_d            = '0;
      res_d.event_res  = EV_ERROR;
      res_d.error_code = fail_code;
      tag_held_d       = 1'b0;
      held_tag_d       = '0;
    end else begin
      if (take) begin
        res_d.tagged_res = 1'b1;
        res_d.tag_number = info;
      end else begin
        res_d.tagged_res = tag_held_q;
        res_d.tag_number = tag_held_q ? held_tag_q : 5'd0;
      end
      if (drop) begin
        tag_held_d = 1'b0;
        held_tag_d = '0;
      end else if (take) begin
        tag_held_d = 1'b1;
        held_tag_d = info;
      end else begin
        tag_held_d = tag_held_q;
        held_tag_d = held_tag_q;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      left_q      <= '0;
      acc_q       <= '0;
      remain_q    <= '0;
      cur_kind_q  <= '0;
      held_tag_q  <= '0;
      tag_held_q  <= 1'b0;
      err_q       <= ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (accept) begin
        phase_q    <= phase_d;
        left_q     <= left_d;
        acc_q      <= acc_d;
        remain_q   <= remain_d;
        cur_kind_q <= cur_kind_d;
        held_tag_q <= held_tag_d;
        tag_held_q <= tag_held_d;
        err_q      <= err_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign event_res_o    = res_q.event_res;
  assign kind_o         = res_q.kind;
  assign value_o        = res_q.value;
  assign payload_byte_o = res_q.payload_byte;
  assign last_o         = res_q.last;
  assign tagged_res_o   = res_q.tagged_res;
  assign tag_number_o   = res_q.tag_number;
  assign error_code_o   = res_q.error_code;

  a_halt_has_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HALT |-> err_q != ERR_NONE)
    else $error("halted without a latched error code");

  a_error_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && event_res_o == EV_ERROR |-> error_code_o != ERR_NONE)
    else $error("error event without an error code");

  a_payload_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> remain_q != 64'd0)
    else $error("payload phase with nothing remaining");

  a_tag_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !tag_held_q |-> held_tag_q == 5'd0)
    else $error("tag number kept without a held tag");

  a_stall_holds_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |=> $stable(phase_q) && $stable(acc_q))
    else $error("decoder state moved while stalled");

endmodule
